/* sv/assert_macros.svh */
// Assertion macros shared by the box filter RTL.
// Uses the clk / arst_n names of the including module; NO_ASSERTIONS strips them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BF3_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("bf3 assertion failed");
`define BF3_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bf3 assertion failed");
`else
`define BF3_ASSERT_ALWAYS(lbl, expr)
`define BF3_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* sv/bf3_pkg.sv */
// Shared types, constants and helpers for the 3x3 box filter.
// No dependencies; imported by every bf3 module.
package bf3_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int PIX_BITS   = 8;

	localparam int DIM_W    = 11;                  // register field width
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = $clog2(MAX_HEIGHT);
	localparam int SUM_W    = 12;                  // 9 * 255 + 4 fits
	localparam int RECIP9   = 3641;                // ceil(2^15 / 9)
	localparam int RECIP_W  = 12;
	localparam int RECIP_SH = 15;
	localparam int PROD_W   = SUM_W + RECIP_W;
	localparam int APB_W    = 32;
	localparam int ADDR_W   = 3;

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);
	localparam logic [DIM_W-1:0] DIM_MIN   = DIM_W'(2);
	localparam logic [DIM_W-1:0] WIDTH_MAX  = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(MAX_HEIGHT);

	typedef logic [PIX_BITS-1:0] pix_t;

	typedef enum logic {
		FUNC_PIXEL = 1'b0,
		FUNC_FLUSH = 1'b1
	} func_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		func_t      func;
		logic [7:0] pixel;
	} pix_beat_t;

	typedef struct packed {
		logic [7:0] avg;
		logic       last_of_frame;
	} res_beat_t;

	// per-item window control, decided when the beat is taken
	typedef struct packed {
		logic emit;
		logic col0;
		logic mask_l;
		logic mask_r;
		logic mask_t;
		logic mask_b;
		logic last;
	} win_ctrl_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		if (v < DIM_MIN) begin
			r = DIM_MIN;
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* sv/bf3_linebuf.sv */
// Two-row line buffer, both rows packed in one word per column.
// Word layout {older row, previous row}; registered read. Uses bf3_pkg.
module bf3_linebuf (
	input  logic                            clk,
	input  logic                            we,
	input  logic [bf3_pkg::COL_W-1:0]       waddr,
	input  logic [2*bf3_pkg::PIX_BITS-1:0]  wdata,
	input  logic                            re,
	input  logic [bf3_pkg::COL_W-1:0]       raddr,
	output logic [2*bf3_pkg::PIX_BITS-1:0]  rdata
);
	import bf3_pkg::*;

	logic [2*PIX_BITS-1:0] mem_q [MAX_WIDTH];
	logic [2*PIX_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/bf3_window.sv */
// 3x3 window columns, edge masking and neighborhood sum.
// Uses bf3_pkg; sum is combinational from the stage-1 beat.
module bf3_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift,
	input  bf3_pkg::win_ctrl_t         ctrl,
	input  bf3_pkg::pix_t              up,
	input  bf3_pkg::pix_t              mid,
	input  bf3_pkg::pix_t              pix,
	output logic [bf3_pkg::SUM_W-1:0]  sum
);
	import bf3_pkg::*;

	pix_t col1_q [3];
	pix_t col2_q [3];
	pix_t new_col [3];
	pix_t nb [3][3];

	assign new_col[0] = up;
	assign new_col[1] = mid;
	assign new_col[2] = pix;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			nb[r][0] = col1_q[r];
			nb[r][1] = col2_q[r];
			// first column of a row: right neighbor is the row wrap, not a pixel
			nb[r][2] = ctrl.col0 ? '0 : new_col[r];
			if (ctrl.mask_l) nb[r][0] = '0;
			if (ctrl.mask_r) nb[r][2] = '0;
		end
		for (int c = 0; c < 3; c++) begin
			if (ctrl.mask_t) nb[0][c] = '0;
			if (ctrl.mask_b) nb[2][c] = '0;
		end
	end

	always_comb begin
		sum = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				sum = sum + SUM_W'(nb[r][c]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				col1_q[r] <= '0;
				col2_q[r] <= '0;
			end
		end else if (shift) begin
			for (int r = 0; r < 3; r++) begin
				col1_q[r] <= col2_q[r];
				col2_q[r] <= new_col[r];
			end
		end
	end

endmodule

/* sv/bf3_div9.sv */
// Rounded divide-by-nine and result register.
// Uses bf3_pkg; floor((sum+4)/9) by reciprocal multiply.
module bf3_div9 (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic                       in_valid,
	input  logic [bf3_pkg::SUM_W-1:0]  sum,
	input  logic                       last,
	output logic                       out_valid,
	output bf3_pkg::res_beat_t         out_beat
);
	import bf3_pkg::*;

	logic [SUM_W-1:0]  rounded;
	logic [PROD_W-1:0] prod;
	logic              valid_s3;
	res_beat_t         beat_s3;

	assign rounded = sum + SUM_W'(4);
	// exact for every value below 2^15
	assign prod    = PROD_W'(rounded) * PROD_W'(RECIP9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (load) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			beat_s3.avg           <= prod[RECIP_SH +: 8];
			beat_s3.last_of_frame <= last;
		end
	end

	assign out_valid = valid_s3;
	assign out_beat  = beat_s3;

endmodule

/* sv/box_filter_3x3_mean_core.sv */
// 3x3 box filter, zero padded, rounded mean; raster pixels in, one mean per beat out.
// The beat of pixel k+width+1 yields the mean of pixel k via stage 1, 2 and 3 registers.
// Throughput: one beat per cycle if unstalled; set by the one line-buffer word per column.
// Reset: asynchronous; width and height return to 64, counters and window clear.
// Line buffers are not cleared: rows above the frame are always masked out.
module box_filter_3x3_mean_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pix_valid,
	output logic                           pix_stall,
	input  bf3_pkg::pix_beat_t             pix_beat,
	output logic                           res_valid,
	input  logic                           res_stall,
	output bf3_pkg::res_beat_t             res_beat,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bf3_pkg::ADDR_W-1:0]     paddr,
	input  logic [bf3_pkg::APB_W-1:0]      pwdata,
	output logic [bf3_pkg::APB_W-1:0]      prdata,
	output logic                           pready
);
	import bf3_pkg::*;
	`include "assert_macros.svh"

	logic [DIM_W-1:0] w_q, h_q;
	logic [COL_W-1:0] in_col_q, out_col_q;
	logic [DIM_W-1:0] in_row_q;
	logic [ROW_W-1:0] out_row_q;

	logic cfg_wr, ignore, take, ready1, ready2, ready3, mv1;
	logic past_frame;
	logic [DIM_W-1:0] col_nx;
	win_ctrl_t ctrl_nx;
	pix_t pix_nx;
	reg_idx_t reg_sel;

	logic             valid_s1, valid_s2, last_s2;
	win_ctrl_t        ctrl_s1;
	pix_t             pix_s1;
	logic [COL_W-1:0] addr_s1;
	logic [SUM_W-1:0] sum, sum_s2;
	logic [2*PIX_BITS-1:0] rd;

	// ---- configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_comb begin
		unique case (reg_sel)
			REG_WIDTH:  prdata = APB_W'(w_q);
			REG_HEIGHT: prdata = APB_W'(h_q);
			default:    prdata = '0;
		endcase
	end

	// ---- input beat decode
	assign past_frame = in_row_q >= h_q;
	assign ignore     = (pix_beat.func == FUNC_FLUSH) && !past_frame;
	assign ready3     = !res_valid || !res_stall;
	assign ready2     = !valid_s2 || ready3;
	assign ready1     = !valid_s1 || ready2;
	assign pix_stall  = !ready1;
	assign take       = pix_valid && ready1 && !ignore;
	assign mv1        = valid_s1 && ready2;

	assign pix_nx = past_frame ? '0 : pix_t'(pix_beat.pixel);
	assign col_nx = DIM_W'(in_col_q) + DIM_W'(1);

	always_comb begin
		ctrl_nx.emit   = (in_row_q >= DIM_W'(2)) ||
			((in_row_q == DIM_W'(1)) && (in_col_q != '0));
		ctrl_nx.col0   = (in_col_q == '0);
		ctrl_nx.mask_l = (out_col_q == '0);
		ctrl_nx.mask_r = (DIM_W'(out_col_q) == (w_q - DIM_W'(1)));
		ctrl_nx.mask_t = (out_row_q == '0);
		ctrl_nx.mask_b = (DIM_W'(out_row_q) == (h_q - DIM_W'(1)));
		ctrl_nx.last   = ctrl_nx.emit && ctrl_nx.mask_r && ctrl_nx.mask_b;
	end

	// ---- dimensions and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= DIM_RESET;
			h_q       <= DIM_RESET;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_WIDTH:  w_q <= clamp_dim(pwdata[DIM_W-1:0], WIDTH_MAX);
				REG_HEIGHT: h_q <= clamp_dim(pwdata[DIM_W-1:0], HEIGHT_MAX);
				default:    ;
			endcase
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			if (ctrl_nx.last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (col_nx >= w_q) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + DIM_W'(1);
				end else begin
					in_col_q <= col_nx[COL_W-1:0];
				end
				if (ctrl_nx.emit) begin
					if (ctrl_nx.mask_r) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ROW_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
		end
	end

	// ---- stage 1: beat plus line-buffer read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready1) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctrl_s1 <= ctrl_nx;
			pix_s1  <= pix_nx;
			addr_s1 <= in_col_q;
		end
	end

	bf3_linebuf u_linebuf (
		.clk   (clk),
		.we    (mv1),
		.waddr (addr_s1),
		.wdata ({rd[PIX_BITS-1:0], pix_s1}),
		.re    (take),
		.raddr (in_col_q),
		.rdata (rd)
	);

	bf3_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (mv1),
		.ctrl   (ctrl_s1),
		.up     (rd[2*PIX_BITS-1:PIX_BITS]),
		.mid    (rd[PIX_BITS-1:0]),
		.pix    (pix_s1),
		.sum    (sum)
	);

	// ---- stage 2: neighborhood sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready2) begin
			valid_s2 <= valid_s1 && ctrl_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (ready2) begin
			sum_s2  <= sum;
			last_s2 <= ctrl_s1.last;
		end
	end

	// ---- stage 3: divide and result register
	bf3_div9 u_div9 (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (ready3),
		.in_valid  (valid_s2),
		.sum       (sum_s2),
		.last      (last_s2),
		.out_valid (res_valid),
		.out_beat  (res_beat)
	);

	`BF3_ASSERT_NEXT(a_cfg_restart, cfg_wr, (in_col_q == '0) && (in_row_q == '0) && (out_row_q == '0))
	`BF3_ASSERT_ALWAYS(a_in_col_range, DIM_W'(in_col_q) < w_q)
	`BF3_ASSERT_ALWAYS(a_out_col_range, DIM_W'(out_col_q) < w_q)
	`BF3_ASSERT_NEXT(a_s2_hold, valid_s2 && !ready3, valid_s2 && $stable(sum_s2) && $stable(last_s2))

endmodule
